// ===== sv/cvr_pkg.sv =====
package cvr_pkg;

  localparam int XY_W = 18;
  localparam int Z_W = 16;
  localparam int PROD_W = 33;
  localparam int OUT_W = 12;
  localparam int GAIN_W = 14;
  localparam int SAT_W = 20;
  localparam int MAX_ITER = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd9949;

  // start vector for rotation: 1.0 in 5.13
  localparam logic signed [XY_W-1:0] X_START = 18'sd8192;
  localparam logic signed [Z_W-1:0] QUARTER = 16'sd4096;

  // exact answers for the four special angles
  localparam logic signed [OUT_W-1:0] OUT_MAX = 12'sd2047;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -12'sd2048;
  localparam logic signed [OUT_W-1:0] ANG_NEG_ONE = -12'sd2048;
  localparam logic signed [OUT_W-1:0] ANG_NEG_HALF = -12'sd1024;
  localparam logic signed [OUT_W-1:0] ANG_HALF = 12'sd1024;

  // arctan(2^-i)/pi in 2.14
  localparam logic [Z_W-1:0] ATAN_TAB [MAX_ITER] = '{
    16'h0FFF, 16'h0972, 16'h04FD, 16'h0288, 16'h0145, 16'h00A2, 16'h0051, 16'h0028,
    16'h0014, 16'h000A, 16'h0005, 16'h0002, 16'h0001, 16'h0000, 16'h0000, 16'h0000
  };

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_POS,
    DIR_NEG
  } dir_t;

  typedef struct packed {
    logic                    vld;
    logic                    vect;
    dir_t                    dir;
    logic                    special;
    logic signed [OUT_W-1:0] sp_cos;
    logic signed [OUT_W-1:0] sp_sin;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } work_t;

  function automatic logic signed [OUT_W-1:0] sat12(input logic signed [SAT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < SAT_W'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/cvr_pre.sv =====
module cvr_pre (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           op,
  input  logic signed [cvr_pkg::OUT_W-1:0] in_angle,
  input  logic signed [cvr_pkg::OUT_W-1:0] in_x,
  input  logic signed [cvr_pkg::OUT_W-1:0] in_y,
  output cvr_pkg::work_t                 q
);

  cvr_pkg::work_t d;
  logic signed [cvr_pkg::Z_W-1:0] a4;
  logic signed [cvr_pkg::Z_W-1:0] zf;
  logic signed [cvr_pkg::XY_W-1:0] xv;
  logic signed [cvr_pkg::XY_W-1:0] yv;

  assign a4 = {{2{in_angle[11]}}, in_angle, 2'b00};
  assign xv = {{4{in_x[11]}}, in_x, 2'b00};
  assign yv = {{4{in_y[11]}}, in_y, 2'b00};

  always_comb begin
    d = '0;
    d.vld = take;
    d.vect = op;
    d.dir = cvr_pkg::DIR_NONE;
    zf = a4;
    if (!op) begin
      // exact table answers
      if (in_angle == cvr_pkg::ANG_NEG_ONE) begin
        d.special = 1'b1;
        d.sp_cos = cvr_pkg::OUT_MIN;
      end else if (in_angle == cvr_pkg::ANG_NEG_HALF) begin
        d.special = 1'b1;
        d.sp_sin = cvr_pkg::OUT_MIN;
      end else if (in_angle == '0) begin
        d.special = 1'b1;
        d.sp_cos = cvr_pkg::OUT_MAX;
      end else if (in_angle == cvr_pkg::ANG_HALF) begin
        d.special = 1'b1;
        d.sp_sin = cvr_pkg::OUT_MAX;
      end
      // quarter-turn fold into [-0.5, 0.5)
      if (a4 >= cvr_pkg::QUARTER) begin
        zf = a4 - cvr_pkg::QUARTER;
        d.dir = cvr_pkg::DIR_POS;
      end else if (a4 <= -cvr_pkg::QUARTER) begin
        zf = a4 + cvr_pkg::QUARTER;
        d.dir = cvr_pkg::DIR_NEG;
      end
      d.x = cvr_pkg::X_START;
      d.y = '0;
      d.z = {zf[cvr_pkg::Z_W-2:0], 1'b0};
    end else begin
      d.x = xv;
      d.y = yv;
      d.z = '0;
      if (in_x[11]) begin
        if (in_y[11] || in_y == '0) begin
          d.x = -yv;
          d.y = xv;
          d.dir = cvr_pkg::DIR_POS;
        end else begin
          d.x = yv;
          d.y = -xv;
          d.dir = cvr_pkg::DIR_NEG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= d;
    end
  end

endmodule

// ===== sv/cvr_stage.sv =====
module cvr_stage #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  cvr_pkg::work_t d,
  output cvr_pkg::work_t q
);

  cvr_pkg::work_t n;
  logic pos;
  logic signed [cvr_pkg::XY_W-1:0] xs;
  logic signed [cvr_pkg::XY_W-1:0] ys;
  logic signed [cvr_pkg::Z_W-1:0] step;

  assign step = signed'(cvr_pkg::ATAN_TAB[SHIFT]);
  assign xs = d.x >>> SHIFT;
  assign ys = d.y >>> SHIFT;
  // vectoring drives y to zero, rotation drives z to zero
  assign pos = d.vect ? d.y[cvr_pkg::XY_W-1] : !d.z[cvr_pkg::Z_W-1];

  always_comb begin
    n = d;
    if (pos) begin
      n.x = d.x - ys;
      n.y = d.y + xs;
      n.z = d.z - step;
    end else begin
      n.x = d.x + ys;
      n.y = d.y - xs;
      n.z = d.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= n;
    end
  end

endmodule

// ===== sv/cvr_post.sv =====
module cvr_post (
  input  logic                              clk,
  input  logic                              rst,
  input  cvr_pkg::work_t                    d,
  input  logic [cvr_pkg::GAIN_W-1:0]        gain,
  output logic                              done,
  output logic signed [cvr_pkg::OUT_W-1:0]  out_cos,
  output logic signed [cvr_pkg::OUT_W-1:0]  out_sin,
  output logic signed [cvr_pkg::OUT_W-1:0]  out_angle
);

  typedef struct packed {
    logic                             vld;
    logic                             vect;
    cvr_pkg::dir_t                    dir;
    logic                             special;
    logic signed [cvr_pkg::OUT_W-1:0] sp_cos;
    logic signed [cvr_pkg::OUT_W-1:0] sp_sin;
    logic signed [cvr_pkg::PROD_W-1:0] px;
    logic signed [cvr_pkg::PROD_W-1:0] py;
    logic signed [cvr_pkg::Z_W-1:0]   z;
  } mul_t;

  mul_t m;
  logic signed [cvr_pkg::GAIN_W:0] gain_s;
  logic signed [cvr_pkg::PROD_W-1:0] gx_full;
  logic signed [cvr_pkg::PROD_W-1:0] gy_full;
  logic signed [cvr_pkg::SAT_W-1:0] gx;
  logic signed [cvr_pkg::SAT_W-1:0] gy;
  logic signed [cvr_pkg::SAT_W-1:0] rx;
  logic signed [cvr_pkg::SAT_W-1:0] ry;
  logic signed [cvr_pkg::Z_W:0] zh;
  logic signed [cvr_pkg::Z_W:0] za;
  logic signed [cvr_pkg::OUT_W-1:0] cos_next;
  logic signed [cvr_pkg::OUT_W-1:0] sin_next;
  logic signed [cvr_pkg::OUT_W-1:0] angle_next;

  assign gain_s = {1'b0, gain};

  // gain compensation multiply
  always_ff @(posedge clk) begin
    m.vect <= d.vect;
    m.dir <= d.dir;
    m.special <= d.special;
    m.sp_cos <= d.sp_cos;
    m.sp_sin <= d.sp_sin;
    m.px <= cvr_pkg::PROD_W'(d.x) * cvr_pkg::PROD_W'(gain_s);
    m.py <= cvr_pkg::PROD_W'(d.y) * cvr_pkg::PROD_W'(gain_s);
    m.z <= d.z;
    if (rst) begin
      m.vld <= 1'b0;
    end else begin
      m.vld <= d.vld;
    end
  end

  assign gx_full = m.px >>> cvr_pkg::GAIN_W;
  assign gy_full = m.py >>> cvr_pkg::GAIN_W;
  assign gx = gx_full[cvr_pkg::SAT_W-1:0];
  assign gy = gy_full[cvr_pkg::SAT_W-1:0];

  always_comb begin
    case (m.dir)
      cvr_pkg::DIR_POS: begin
        rx = -gy;
        ry = gx;
      end
      cvr_pkg::DIR_NEG: begin
        rx = gy;
        ry = -gx;
      end
      default: begin
        rx = gx;
        ry = gy;
      end
    endcase

    zh = $signed({m.z[cvr_pkg::Z_W-1], m.z}) >>> 1;
    case (m.dir)
      cvr_pkg::DIR_POS: za = zh - (cvr_pkg::Z_W+1)'(cvr_pkg::QUARTER);
      cvr_pkg::DIR_NEG: za = zh + (cvr_pkg::Z_W+1)'(cvr_pkg::QUARTER);
      default:          za = zh;
    endcase

    cos_next = '0;
    sin_next = '0;
    angle_next = '0;
    if (m.vect) begin
      angle_next = cvr_pkg::sat12(cvr_pkg::SAT_W'(za >>> 2));
    end else if (m.special) begin
      cos_next = m.sp_cos;
      sin_next = m.sp_sin;
    end else begin
      cos_next = cvr_pkg::sat12(rx >>> 2);
      sin_next = cvr_pkg::sat12(ry >>> 2);
    end
  end

  always_ff @(posedge clk) begin
    out_cos <= cos_next;
    out_sin <= sin_next;
    out_angle <= angle_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m.vld;
    end
  end

endmodule

// ===== sv/cordic_rotate_vector_fixed.sv =====
// CORDIC rotation / vectoring unit, 12-bit fixed point.
// Issue a transaction by raising start for one cycle with op and its operands;
// it is taken at any clock edge where start is high and busy is low.
// op = 0: in_angle (1.11, 1.0 = pi) gives out_cos / out_sin, out_angle = 0.
// op = 1: (in_x, in_y) gives out_angle (1.11), out_cos / out_sin = 0.
// Each result appears for exactly one cycle with done high; there is no
// back-pressure, so the consumer must take it then.
// Pipeline: ITERATIONS + 3 register stages in all (operand fold loaded at the
// accepting edge, one stage per CORDIC iteration, gain multiply, output);
// done rises as the output stage is loaded.
// Throughput: one transaction per cycle; busy is only high during reset.
// The pipeline length is set by ITERATIONS, one shift-add stage each.
// inverse_gain is written with cfg_we / cfg_data, 14-bit 0.14 format; write
// it only while no transaction is in flight. Reset value is 9949.
// rst (synchronous) empties the pipeline and restores inverse_gain.
module cordic_rotate_vector_fixed #(
  parameter int ITERATIONS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic signed [cvr_pkg::OUT_W-1:0]  in_angle,
  input  logic signed [cvr_pkg::OUT_W-1:0]  in_x,
  input  logic signed [cvr_pkg::OUT_W-1:0]  in_y,
  input  logic                              cfg_we,
  input  logic [cvr_pkg::GAIN_W-1:0]        cfg_data,
  output logic                              done,
  output logic signed [cvr_pkg::OUT_W-1:0]  out_cos,
  output logic signed [cvr_pkg::OUT_W-1:0]  out_sin,
  output logic signed [cvr_pkg::OUT_W-1:0]  out_angle
);

  logic [cvr_pkg::GAIN_W-1:0] inverse_gain;
  cvr_pkg::work_t pipe [ITERATIONS+1];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_gain <= cvr_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      inverse_gain <= cfg_data;
    end
  end

  cvr_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .take     (start && !busy),
    .op       (op),
    .in_angle (in_angle),
    .in_x     (in_x),
    .in_y     (in_y),
    .q        (pipe[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    cvr_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .d   (pipe[i]),
      .q   (pipe[i+1])
    );
  end

  cvr_post u_post (
    .clk       (clk),
    .rst       (rst),
    .d         (pipe[ITERATIONS]),
    .gain      (inverse_gain),
    .done      (done),
    .out_cos   (out_cos),
    .out_sin   (out_sin),
    .out_angle (out_angle)
  );

endmodule
